// ===== sv/ordered_key_deque_table_defines.svh =====
// Assertion macros for the ordered key deque table.
// Depends on nothing; included by the top level.
`ifndef ORDERED_KEY_DEQUE_TABLE_DEFINES_SVH
`define ORDERED_KEY_DEQUE_TABLE_DEFINES_SVH
`ifndef ASSERT_OFF
`define OKDT_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define OKDT_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OKDT_ASSERT(label, clk, rstn, prop, msg)
`define OKDT_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// ===== sv/okdt_pkg.sv =====
// Shared types and constants for the ordered key deque table.
// Depends on nothing.
package okdt_pkg;
    localparam int Depth = 16;
    localparam int IdxW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);
    localparam int KeyW = 16;

    typedef enum logic [2:0] {
        ACT_ADD_BACK  = 3'd0,
        ACT_ADD_FRONT = 3'd1,
        ACT_REMOVE    = 3'd2,
        ACT_POP_HEAD  = 3'd3,
        ACT_LOOKUP    = 3'd4,
        ACT_SUCC      = 3'd5,
        ACT_NOP6      = 3'd6,
        ACT_NOP7      = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [KeyW-1:0] key;
        logic [KeyW-1:0] cust;
        logic [KeyW-1:0] ride;
    } entry_t;

    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

    typedef struct packed {
        logic busy;
    } stat_t;
endpackage

// ===== sv/okdt_ctrl.sv =====
// Controller state machine for the ordered key deque table.
// Depends on okdt_pkg.
module okdt_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output okdt_pkg::cmd_t cmd,
    output okdt_pkg::stat_t stat
);
    import okdt_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_EXEC;
            end
            S_EXEC: state_next = S_OUT;
            S_OUT: begin
                if (m_tready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = (state_reg == S_IDLE);
        m_tvalid  = (state_reg == S_OUT);
        cmd.load  = (state_reg == S_IDLE) && s_tvalid;
        cmd.exec  = (state_reg == S_EXEC);
        stat.busy = (state_reg != S_IDLE);
    end
endmodule

// ===== sv/okdt_datapath.sv =====
// Datapath: row of entry registers with parallel key compare and shifting.
// Depends on okdt_pkg.
module okdt_datapath (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  okdt_pkg::cmd_t           cmd,
    input  logic [2:0]               in_action,
    input  okdt_pkg::entry_t         in_entry,
    output okdt_pkg::status_t        out_status,
    output okdt_pkg::entry_t         out_entry,
    output logic [okdt_pkg::CntW-1:0] out_count
);
    import okdt_pkg::*;

    entry_t    cells_reg [Depth];
    entry_t    cells_next [Depth];
    logic [CntW-1:0] count_reg, count_next;
    action_t   act_reg;
    entry_t    arg_reg;
    status_t   status_reg, status_next;
    entry_t    res_reg, res_next;
    logic [Depth-1:0] hit;
    logic [Depth-1:0] first;
    logic      any_hit;
    logic [IdxW-1:0] pos;
    logic [IdxW-1:0] succ;
    logic      full, empty;

    always_comb begin
        for (int i = 0; i < Depth; i++) begin
            hit[i] = (cells_reg[i].key == arg_reg.key) && (CntW'(i) < count_reg);
        end
        first = hit & (~hit + Depth'(1));
        any_hit = |hit;
        pos = '0;
        for (int i = 0; i < Depth; i++) begin
            if (first[i]) pos = IdxW'(i);
        end
        if (act_reg == ACT_POP_HEAD) pos = '0;
        if (CntW'(pos) + CntW'(1) >= count_reg) succ = '0;
        else succ = pos + IdxW'(1);
        full  = (count_reg == CntW'(Depth));
        empty = (count_reg == '0);
    end

    always_comb begin
        cells_next  = cells_reg;
        count_next  = count_reg;
        status_next = ST_OK;
        res_next    = '0;
        case (act_reg)
            ACT_ADD_BACK, ACT_ADD_FRONT: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    res_next   = arg_reg;
                    count_next = count_reg + CntW'(1);
                    if (act_reg == ACT_ADD_BACK) begin
                        cells_next[count_reg[IdxW-1:0]] = arg_reg;
                    end else begin
                        for (int i = 1; i < Depth; i++) begin
                            cells_next[i] = cells_reg[i-1];
                        end
                        cells_next[0] = arg_reg;
                    end
                end
            end
            ACT_REMOVE, ACT_POP_HEAD, ACT_LOOKUP, ACT_SUCC: begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else if (act_reg != ACT_POP_HEAD && !any_hit) begin
                    status_next = ST_NOTFOUND;
                end else if (act_reg == ACT_SUCC) begin
                    res_next = cells_reg[succ];
                end else begin
                    res_next = cells_reg[pos];
                    if (act_reg != ACT_LOOKUP) begin
                        count_next = count_reg - CntW'(1);
                        for (int i = 0; i < Depth - 1; i++) begin
                            if (IdxW'(i) >= pos) cells_next[i] = cells_reg[i+1];
                        end
                    end
                end
            end
            default: status_next = ST_OK;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.exec) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg <= action_t'(in_action);
            arg_reg <= in_entry;
        end
        if (cmd.exec) begin
            cells_reg  <= cells_next;
            status_reg <= status_next;
            res_reg    <= res_next;
        end
    end

    assign out_status = status_reg;
    assign out_entry  = res_reg;
    assign out_count  = count_reg;
endmodule

// ===== sv/ordered_key_deque_table.sv =====
// Ordered key deque table: one action per transfer, one result per action.
// An action passes the states accept, execute and present in order; the result is
// valid in present, and no new action is accepted until the result is taken.
// All entries compare keys in parallel and shift in the execute cycle.
// Reset (aresetn low, synchronous) empties the table and clears the handshake.
`include "ordered_key_deque_table_defines.svh"
module ordered_key_deque_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // action[2:0], ticket_key[18:3], customer_ref[34:19], ride_ref[50:35], zero fill
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], found_key[17:2], found_customer[33:18], found_ride[49:34],
    // occupancy[54:50], zero fill
    output logic [55:0] m_tdata
);
    import okdt_pkg::*;

    cmd_t    cmd;
    stat_t   stat;
    status_t st;
    entry_t  res;
    logic [CntW-1:0] cnt;
    entry_t  in_entry;

    assign in_entry.key  = s_tdata[18:3];
    assign in_entry.cust = s_tdata[34:19];
    assign in_entry.ride = s_tdata[50:35];

    okdt_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .cmd(cmd), .stat(stat)
    );

    okdt_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .in_action(s_tdata[2:0]),
        .in_entry(in_entry), .out_status(st), .out_entry(res), .out_count(cnt)
    );

    assign m_tdata = {1'b0, cnt, res.ride, res.cust, res.key, st};

    `OKDT_ASSERT(a_ready_busy, aclk, aresetn, s_tready |-> !stat.busy, "ready while busy")
    `OKDT_ASSERT(a_no_overlap, aclk, aresetn, !(s_tready && m_tvalid), "input and output overlap")
    `OKDT_ASSERT(a_occ_range, aclk, aresetn, cnt <= CntW'(Depth), "occupancy beyond depth")
    `OKDT_ASSERT(a_valid_after, aclk, aresetn, (s_tvalid && s_tready) |=> ##1 m_tvalid, "no result")
endmodule
